// ----- design/swarc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarc_pkg: shared types and helpers
// Word types, list codes, sequencer states and saturating byte arithmetic.
// ----------------------------------------------------------------------------
package swarc_pkg;

  localparam int DIR_ENTRIES_DEF = 256;
  localparam int BW = 41;
  localparam int CW = 40;
  localparam int SW = 32;
  localparam int KW = 48;
  localparam int TW = 63;
  localparam logic [CW-1:0] CAP_RESET = 40'd1048576;

  localparam logic [1:0] GK_NONE = 2'd0;
  localparam logic [1:0] GK_B1   = 2'd1;
  localparam logic [1:0] GK_B2   = 2'd2;

  typedef struct packed {
    logic [KW-1:0] block_key;
    logic [SW-1:0] object_size;
  } req_word_t;

  typedef struct packed {
    logic          hit;
    logic [1:0]    ghost_kind;
    logic          bypassed;
    logic [TW-1:0] total_bytes;
    logic [TW-1:0] hit_bytes;
    logic [CW-1:0] target_recent;
  } rsp_word_t;

  typedef enum logic [2:0] {
    LST_NEVER, LST_T1, LST_T2, LST_B1, LST_B2, LST_FREED
  } list_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_SCANW, S_DECIDE, S_DIV, S_GHOST_UPD,
    S_MOVE_HIT, S_EVICT, S_INSERT, S_TRIM_CHK, S_TRIM_MOVE, S_PUSH
  } state_t;

  function automatic logic [BW-1:0] bytes_upd(input logic [BW-1:0] v, input logic from_m,
                                              input logic to_m, input logic [SW-1:0] s);
    logic [BW-1:0] r;
    logic [BW:0]   sum;
    r = v;
    if (from_m) begin
      r = (r > BW'(s)) ? r - BW'(s) : '0;
    end
    sum = {1'b0, r} + (BW+1)'(s);
    if (to_m) begin
      r = sum[BW] ? {BW{1'b1}} : sum[BW-1:0];
    end
    return r;
  endfunction

  function automatic logic [TW-1:0] add63(input logic [TW-1:0] a, input logic [SW-1:0] b);
    logic [TW:0] sum;
    sum = {1'b0, a} + (TW+1)'(b);
    return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  endfunction

endpackage

// ----- design/size_weighted_arc_replacement_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_weighted_arc_replacement_top: byte-weighted ARC directory
// Keeps T1, T2, B1 and B2 in one directory memory and walks it with a
// single scan sequencer for lookups and LRU searches.
// ----------------------------------------------------------------------------
// Sequence: one directory scan for the lookup, a division on a ghost hit,
// and one further scan for each entry moved or freed while trimming, plus
// a few control states.
// Throughput: one word at a time; the next request is taken after the
// result has been handed to the output register.
// Reset: after rst a clearing pass marks every directory slot empty;
// no request is taken until it ends.
module size_weighted_arc_replacement_top #(
  parameter int DIRECTORY_ENTRIES = swarc_pkg::DIR_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  swarc_pkg::req_word_t      req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output swarc_pkg::rsp_word_t      rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [swarc_pkg::CW-1:0]  cfg_data
);
  import swarc_pkg::*;

  localparam int IW = $clog2(DIRECTORY_ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(DIRECTORY_ENTRIES - 1);

  list_t         list_mem  [DIRECTORY_ENTRIES];
  logic [KW-1:0] key_mem   [DIRECTORY_ENTRIES];
  logic [SW-1:0] size_mem  [DIRECTORY_ENTRIES];
  logic [CW-1:0] stamp_mem [DIRECTORY_ENTRIES];

  state_t        state, state_next;
  logic [IW-1:0] cnt;
  logic          pv;
  logic [IW-1:0] paddr;
  list_t         rd_list;
  logic [KW-1:0] rd_key;
  logic [SW-1:0] rd_size;
  logic [CW-1:0] rd_stamp;
  logic [CW-1:0] eff_stamp;

  req_word_t     cur;
  logic [CW-1:0] capacity;
  logic [CW-1:0] target;
  logic [CW-1:0] stamp_counter;
  logic [BW-1:0] br, bf, bgr, bgf;
  logic [TW-1:0] total_counter, hit_counter;
  logic          fl_hit, fl_byp, trim_after, in_trim;
  logic [1:0]    fl_ghost;
  logic [1:0]    phase;
  logic [IW-1:0] slot;

  logic          fd_v;
  logic [IW-1:0] fd_idx;
  list_t         fd_list;
  logic [SW-1:0] fd_size;
  logic          fr_v;
  logic [IW-1:0] fr_idx;
  logic [CW-1:0] fr_stamp;
  logic          gh_v;
  logic [IW-1:0] gh_idx;
  list_t         gh_list;
  logic [SW-1:0] gh_size;
  logic [CW-1:0] gh_stamp;
  logic          lr_v;
  logic [IW-1:0] lr_idx;
  logic [SW-1:0] lr_size;
  logic [CW-1:0] lr_stamp;
  list_t         scan_list;

  logic          mv_en;
  logic [IW-1:0] mv_idx;
  list_t         mv_from, mv_to;
  logic [SW-1:0] mv_size;
  logic          lst_we;
  logic [IW-1:0] lst_wa;
  list_t         lst_wd;
  logic          ins_we;

  logic          div_start, div_done;
  logic [BW-1:0] div_q;
  logic [CW-1:0] lim_t2;
  logic [BW:0]   sum_b1, sum_b2;
  logic          trim_cond;
  list_t         ph_list, ph_dst;
  logic [BW-1:0] step;
  logic [BW:0]   tgt_up;
  logic          rsp_load;
  logic          found_live, found_ghost;

  swarc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ((fd_list == LST_B1) ? bgf : bgr),
    .divisor  ((fd_list == LST_B1) ? bgr : bgf),
    .done     (div_done),
    .quotient (div_q)
  );

  assign found_live  = fd_v && (fd_list == LST_T1 || fd_list == LST_T2);
  assign found_ghost = fd_v && (fd_list == LST_B1 || fd_list == LST_B2);
  assign eff_stamp   = (rd_list == LST_NEVER) ? '0 : rd_stamp;
  assign lim_t2      = (capacity > target) ? capacity - target : '0;
  assign sum_b1      = {1'b0, bgr} + {1'b0, br};
  assign sum_b2      = {1'b0, bgf} + {1'b0, bf};
  assign step        = (BW'(fd_size) > div_q) ? BW'(fd_size) : div_q;
  assign tgt_up      = (BW+1)'(target) + {1'b0, step};
  assign rsp_load    = (state == S_PUSH) && (!rsp_valid || !rsp_stall);
  assign cfg_ready   = 1'b1;

  always_comb begin
    unique case (phase)
      2'd0: begin
        trim_cond = br > BW'(target);
        ph_list   = LST_T1;
        ph_dst    = LST_B1;
      end
      2'd1: begin
        trim_cond = (bgr != '0) && (sum_b1 > (BW+1)'(capacity));
        ph_list   = LST_B1;
        ph_dst    = LST_FREED;
      end
      2'd2: begin
        trim_cond = bf > BW'(lim_t2);
        ph_list   = LST_T2;
        ph_dst    = LST_B2;
      end
      default: begin
        trim_cond = (bgf != '0) && (sum_b2 > (BW+1)'(capacity));
        ph_list   = LST_B2;
        ph_dst    = LST_FREED;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (cnt == LAST) state_next = S_IDLE;
      S_IDLE:      if (req_valid) state_next = S_SCAN;
      S_SCAN:      if (cnt == LAST) state_next = S_SCANW;
      S_SCANW:     state_next = in_trim ? S_TRIM_MOVE : S_DECIDE;
      S_DECIDE: begin
        priority if (found_live) state_next = S_MOVE_HIT;
        else if (found_ghost) state_next = S_DIV;
        else if (BW'(cur.object_size) > BW'(capacity)) state_next = S_PUSH;
        else if (fr_v) state_next = S_INSERT;
        else if (gh_v) state_next = S_EVICT;
        else state_next = S_PUSH;
      end
      S_DIV:       if (div_done) state_next = S_GHOST_UPD;
      S_GHOST_UPD: state_next = S_MOVE_HIT;
      S_MOVE_HIT:  state_next = trim_after ? S_TRIM_CHK : S_PUSH;
      S_EVICT:     state_next = S_INSERT;
      S_INSERT:    state_next = S_TRIM_CHK;
      S_TRIM_CHK: begin
        if (trim_cond) state_next = S_SCAN;
        else if (phase == 2'd3) state_next = S_PUSH;
      end
      S_TRIM_MOVE: begin
        if (!lr_v && phase == 2'd3) state_next = S_PUSH;
        else state_next = S_TRIM_CHK;
      end
      S_PUSH:      if (rsp_load) state_next = S_IDLE;
      default:     state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    req_stall = (state != S_IDLE);
    div_start = (state == S_DECIDE) && !found_live && found_ghost;
    mv_en     = 1'b0;
    mv_idx    = fd_idx;
    mv_from   = fd_list;
    mv_to     = LST_T2;
    mv_size   = fd_size;
    ins_we    = 1'b0;
    unique case (state)
      S_MOVE_HIT: mv_en = 1'b1;
      S_EVICT: begin
        mv_en   = 1'b1;
        mv_idx  = gh_idx;
        mv_from = gh_list;
        mv_to   = LST_FREED;
        mv_size = gh_size;
      end
      S_INSERT: begin
        mv_en   = 1'b1;
        ins_we  = 1'b1;
        mv_idx  = slot;
        mv_from = LST_NEVER;
        mv_to   = LST_T1;
        mv_size = cur.object_size;
      end
      S_TRIM_MOVE: begin
        mv_en   = lr_v;
        mv_idx  = lr_idx;
        mv_from = scan_list;
        mv_to   = ph_dst;
        mv_size = lr_size;
      end
      default: ;
    endcase
    lst_we = mv_en || (state == S_CLEAR);
    lst_wa = (state == S_CLEAR) ? cnt : mv_idx;
    lst_wd = (state == S_CLEAR) ? LST_NEVER : mv_to;
  end

  always_ff @(posedge clk) begin
    if (lst_we) begin
      list_mem[lst_wa] <= lst_wd;
    end
    if (mv_en && mv_to != LST_FREED) begin
      stamp_mem[mv_idx] <= stamp_counter;
    end
    if (ins_we) begin
      key_mem[slot]  <= cur.block_key;
      size_mem[slot] <= cur.object_size;
    end
    rd_list  <= list_mem[cnt];
    rd_key   <= key_mem[cnt];
    rd_size  <= size_mem[cnt];
    rd_stamp <= stamp_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      pv            <= 1'b0;
      capacity      <= CAP_RESET;
      target        <= CAP_RESET >> 1;
      stamp_counter <= '0;
      br            <= '0;
      bf            <= '0;
      bgr           <= '0;
      bgf           <= '0;
      total_counter <= '0;
      hit_counter   <= '0;
      rsp_valid     <= 1'b0;
      in_trim       <= 1'b0;
      phase         <= '0;
    end else begin
      state <= state_next;
      pv    <= (state == S_SCAN);
      paddr <= cnt;

      if ((state == S_CLEAR || state == S_SCAN) && cnt != LAST) begin
        cnt <= cnt + IW'(1);
      end else if (state != S_SCAN || cnt == LAST) begin
        cnt <= '0;
      end

      if (state == S_SCAN && cnt == '0) begin
        fd_v <= 1'b0;
        fr_v <= 1'b0;
        gh_v <= 1'b0;
        lr_v <= 1'b0;
      end else if (pv) begin
        if (!fd_v && rd_key == cur.block_key &&
            (rd_list == LST_T1 || rd_list == LST_T2 ||
             rd_list == LST_B1 || rd_list == LST_B2)) begin
          fd_v    <= 1'b1;
          fd_idx  <= paddr;
          fd_list <= rd_list;
          fd_size <= rd_size;
        end
        if ((rd_list == LST_NEVER || rd_list == LST_FREED) &&
            (!fr_v || eff_stamp < fr_stamp)) begin
          fr_v     <= 1'b1;
          fr_idx   <= paddr;
          fr_stamp <= eff_stamp;
        end
        if ((rd_list == LST_B1 || rd_list == LST_B2) &&
            (!gh_v || rd_stamp < gh_stamp)) begin
          gh_v     <= 1'b1;
          gh_idx   <= paddr;
          gh_list  <= rd_list;
          gh_size  <= rd_size;
          gh_stamp <= rd_stamp;
        end
        if (rd_list == scan_list && (!lr_v || rd_stamp < lr_stamp)) begin
          lr_v     <= 1'b1;
          lr_idx   <= paddr;
          lr_size  <= rd_size;
          lr_stamp <= rd_stamp;
        end
      end

      if (state == S_IDLE && req_valid) begin
        cur           <= req;
        total_counter <= add63(total_counter, req.object_size);
        fl_hit        <= 1'b0;
        fl_byp        <= 1'b0;
        fl_ghost      <= GK_NONE;
        in_trim       <= 1'b0;
        trim_after    <= 1'b1;
        phase         <= '0;
      end

      if (state == S_DECIDE) begin
        priority if (found_live) begin
          fl_hit      <= 1'b1;
          hit_counter <= add63(hit_counter, cur.object_size);
          trim_after  <= (fd_list == LST_T1);
        end else if (found_ghost) begin
          fl_ghost <= (fd_list == LST_B1) ? GK_B1 : GK_B2;
        end else if (BW'(cur.object_size) > BW'(capacity)) begin
          fl_byp <= 1'b1;
        end else if (fr_v) begin
          slot <= fr_idx;
        end else if (gh_v) begin
          slot <= gh_idx;
        end else begin
          fl_byp <= 1'b1;
        end
      end

      if (cfg_valid) begin
        capacity <= cfg_data;
        target   <= cfg_data >> 1;
      end else if (state == S_GHOST_UPD) begin
        if (fd_list == LST_B1) begin
          target <= (tgt_up > (BW+1)'(capacity)) ? capacity : tgt_up[CW-1:0];
        end else begin
          target <= (BW'(target) > step) ? target - step[CW-1:0] : '0;
        end
      end

      if (mv_en) begin
        br  <= bytes_upd(br,  mv_from == LST_T1, mv_to == LST_T1, mv_size);
        bf  <= bytes_upd(bf,  mv_from == LST_T2, mv_to == LST_T2, mv_size);
        bgr <= bytes_upd(bgr, mv_from == LST_B1, mv_to == LST_B1, mv_size);
        bgf <= bytes_upd(bgf, mv_from == LST_B2, mv_to == LST_B2, mv_size);
        if (mv_to != LST_FREED) begin
          stamp_counter <= stamp_counter + CW'(1);
        end
      end

      if (state == S_TRIM_CHK) begin
        if (trim_cond) begin
          in_trim   <= 1'b1;
          scan_list <= ph_list;
        end else if (phase != 2'd3) begin
          phase <= phase + 2'd1;
        end
      end
      if (state == S_TRIM_MOVE && !lr_v && phase != 2'd3) begin
        phase <= phase + 2'd1;
      end

      if (rsp_load) begin
        rsp_valid         <= 1'b1;
        rsp.hit           <= fl_hit;
        rsp.ghost_kind    <= fl_ghost;
        rsp.bypassed      <= fl_byp;
        rsp.total_bytes   <= total_counter;
        rsp.hit_bytes     <= hit_counter;
        rsp.target_recent <= target;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/swarc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarc_div: restoring divider
// Unsigned divider producing one quotient bit per cycle; a zero divisor
// gives a zero quotient.
// ----------------------------------------------------------------------------
module swarc_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [swarc_pkg::BW-1:0] dividend,
  input  logic [swarc_pkg::BW-1:0] divisor,
  output logic                   done,
  output logic [swarc_pkg::BW-1:0] quotient
);
  import swarc_pkg::*;

  localparam int NW = $clog2(BW + 1);

  logic          busy;
  logic [NW-1:0] cnt;
  logic [BW-1:0] rem;
  logic [BW-1:0] quo;
  logic [BW-1:0] dvs;
  logic [BW:0]   trial;

  assign trial = {rem, quo[BW-1]};
  assign quotient = (dvs == '0) ? '0 : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == NW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(BW);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
        end
        if (trial >= {1'b0, dvs}) begin
          rem <= BW'(trial - {1'b0, dvs});
          quo <= {quo[BW-2:0], 1'b1};
        end else begin
          rem <= trial[BW-1:0];
          quo <= {quo[BW-2:0], 1'b0};
        end
      end
    end
  end

endmodule

// ----- design/swarc_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarc_chk: port checker
// Watches the top level's ports for ordering and result consistency.
// ----------------------------------------------------------------------------
module swarc_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input swarc_pkg::rsp_word_t rsp
);
  import swarc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid && req_stall)
    else $error("result or ready right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a word is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result word changed");

  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (rsp.ghost_kind == GK_NONE && !rsp.bypassed))
    else $error("hit word also flags a ghost hit or bypass");

endmodule

bind size_weighted_arc_replacement_top swarc_chk u_swarc_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
